>>> hdl/segment_min_max_reduce_core_macros.svh
// Assertion macros for the segment min/max reducer checker.
`ifndef SEGMENT_MIN_MAX_REDUCE_CORE_MACROS_SVH
`define SEGMENT_MIN_MAX_REDUCE_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SMMR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define SMMR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also runs through reset.
`define SMMR_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/smmr_pkg.sv
// Shared types and constants for the segment min/max reducer.
`default_nettype none

package smmr_pkg;

  localparam int VAL_W      = 32;
  localparam int ARG_W      = 13;
  localparam int SEG_IN_W   = 10;
  localparam int REQ_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic MODE_MIN = 1'b0;
  localparam logic MODE_MAX = 1'b1;

  typedef enum logic [REQ_W-1:0] {
    REQ_ELEM  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REDUCE_MODE = 2'd0,
    CFG_ROW_LENGTH  = 2'd1,
    CFG_ZERO_EMPTY  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic             reduce_mode;
    logic [ARG_W-1:0] row_length;
    logic             zero_empty;
  } cfg_t;

endpackage

`default_nettype wire

>>> hdl/smmr_store.sv
// Segment store RAM: one write port, one registered read port with write forwarding.
`default_nettype none

module smmr_store #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int WORD_W = 45
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WORD_W-1:0] rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WORD_W-1:0] wr_data
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] q_r;
  logic [ADDR_W-1:0] addr_r;
  logic              fwd_hit_r;
  logic [WORD_W-1:0] fwd_data_r;
  logic [ADDR_W-1:0] watch_addr;
  logic              wr_match;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  // later writes to the held address override the raw read data
  assign watch_addr = rd_en ? rd_addr : addr_r;
  assign wr_match   = wr_en && (wr_addr == watch_addr);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      addr_r <= rd_addr;
    end
    if (wr_match) begin
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (wr_match) begin
      fwd_hit_r <= 1'b1;
    end else if (rd_en) begin
      fwd_hit_r <= 1'b0;
    end
  end

  assign rd_data = fwd_hit_r ? fwd_data_r : q_r;

endmodule

`default_nettype wire

>>> hdl/smmr_engine.sv
// Reduction stage: running pair, segment flush/load, pending write-back and output register.
`default_nettype none

module smmr_engine #(
  parameter int SEGMENT_COUNT = 1024,
  parameter int ROW_MAX       = 4096,
  parameter int DATA_WIDTH    = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire smmr_pkg::cfg_t                      cfg,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [smmr_pkg::REQ_W-1:0]          in_req_type,
  input  wire logic [$clog2(SEGMENT_COUNT)-1:0]    in_seg,
  input  wire logic [smmr_pkg::VAL_W-1:0]          in_value,
  input  wire logic                                in_last_in_row,
  input  wire logic [DATA_WIDTH+smmr_pkg::ARG_W-1:0] rd_data,
  output logic                                     wr_en,
  output logic [$clog2(SEGMENT_COUNT)-1:0]         wr_addr,
  output logic [DATA_WIDTH+smmr_pkg::ARG_W-1:0]    wr_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [smmr_pkg::VAL_W-1:0]        out_read_value,
  output logic [smmr_pkg::ARG_W-1:0]               out_read_arg,
  output logic                                     out_order_error
);

  localparam int SEG_W = $clog2(SEGMENT_COUNT);
  localparam int POS_W = $clog2(ROW_MAX);
  localparam int ARG_W = smmr_pkg::ARG_W;
  localparam int ENT_W = DATA_WIDTH + ARG_W;
  localparam logic [DATA_WIDTH-1:0] VAL_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] VAL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [POS_W-1:0]      POS_LAST = POS_W'(ROW_MAX - 1);

  // stage one item
  logic                  s1_valid_r;
  smmr_pkg::req_t        s1_req_r;
  logic [SEG_W-1:0]      s1_seg_r;
  logic [DATA_WIDTH-1:0] s1_val_r;
  logic                  s1_last_r;

  // running state
  logic [DATA_WIDTH-1:0] run_val_r, run_val_nxt;
  logic [ARG_W-1:0]      run_arg_r, run_arg_nxt;
  logic [SEG_W-1:0]      cur_seg_r, cur_seg_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic                  in_row_r, in_row_nxt;

  // write-back waiting for a free store write slot
  logic                  pend_valid_r, pend_valid_nxt;
  logic [SEG_W-1:0]      pend_addr_r, pend_addr_nxt;
  logic [ENT_W-1:0]      pend_data_r, pend_data_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic signed [smmr_pkg::VAL_W-1:0] out_value_r, out_value_nxt;
  logic [ARG_W-1:0]      out_arg_r, out_arg_nxt;
  logic                  out_err_r, out_err_nxt;

  logic                  s1_fire;
  logic                  pend_hit;
  logic [ENT_W-1:0]      ent;
  logic [DATA_WIDTH-1:0] ent_val;
  logic [ARG_W-1:0]      ent_arg;
  logic                  row_start, seg_up, seg_down, reload;
  logic [DATA_WIDTH-1:0] base_val, cand_val, rd_val;
  logic [ARG_W-1:0]      base_arg, cand_arg;
  logic [POS_W-1:0]      base_pos;
  logic [SEG_W-1:0]      new_seg;
  logic                  beats;

  logic                  wa_en;
  logic [SEG_W-1:0]      wa_addr;
  logic [ENT_W-1:0]      wa_data;
  logic                  pn_en;
  logic [ENT_W-1:0]      pn_data;

  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  assign pend_hit = pend_valid_r && (pend_addr_r == s1_seg_r);
  assign ent      = pend_hit ? pend_data_r : rd_data;
  assign ent_val  = ent[ENT_W-1 -: DATA_WIDTH];
  assign ent_arg  = ent[ARG_W-1:0];

  assign row_start = !in_row_r;
  assign seg_up    = in_row_r && (s1_seg_r > cur_seg_r);
  assign seg_down  = in_row_r && (s1_seg_r < cur_seg_r);
  assign reload    = row_start || seg_up;
  assign base_val  = reload ? ent_val : run_val_r;
  assign base_arg  = reload ? ent_arg : run_arg_r;
  assign base_pos  = row_start ? '0 : pos_r;
  assign new_seg   = reload ? s1_seg_r : cur_seg_r;

  assign beats = (cfg.reduce_mode == smmr_pkg::MODE_MAX) ?
                 ($signed(s1_val_r) > $signed(base_val)) :
                 ($signed(s1_val_r) < $signed(base_val));
  assign cand_val = beats ? s1_val_r : base_val;
  assign cand_arg = beats ? ARG_W'(base_pos) : base_arg;

  always_comb begin
    rd_val = ent_val;
    if (cfg.zero_empty &&
        (ent_val == ((cfg.reduce_mode == smmr_pkg::MODE_MAX) ? VAL_MIN : VAL_MAX))) begin
      rd_val = '0;
    end
  end

  always_comb begin
    run_val_nxt   = run_val_r;
    run_arg_nxt   = run_arg_r;
    cur_seg_nxt   = cur_seg_r;
    pos_nxt       = pos_r;
    in_row_nxt    = in_row_r;
    wa_en         = 1'b0;
    wa_addr       = cur_seg_r;
    wa_data       = {run_val_r, run_arg_r};
    pn_en         = 1'b0;
    pn_data       = {cand_val, cand_arg};
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    out_arg_nxt   = out_arg_r;
    out_err_nxt   = out_err_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = '0;
      out_arg_nxt   = '0;
      out_err_nxt   = 1'b0;
      case (s1_req_r)
        smmr_pkg::REQ_ELEM: begin
          if (seg_down) begin
            out_err_nxt = 1'b1;
          end else begin
            run_val_nxt = cand_val;
            run_arg_nxt = cand_arg;
            cur_seg_nxt = new_seg;
            // seg_up: flush old pair through the port now
            wa_en = seg_up;
            if (s1_last_r) begin
              in_row_nxt = 1'b0;
              pos_nxt    = '0;
              if (seg_up) begin
                pn_en = 1'b1;
              end else begin
                wa_en   = 1'b1;
                wa_addr = new_seg;
                wa_data = {cand_val, cand_arg};
              end
            end else begin
              in_row_nxt = 1'b1;
              pos_nxt    = (base_pos < POS_LAST) ? base_pos + 1'b1 : base_pos;
            end
          end
        end
        smmr_pkg::REQ_WRITE: begin
          wa_en   = 1'b1;
          wa_addr = s1_seg_r;
          wa_data = {s1_val_r, cfg.row_length};
        end
        smmr_pkg::REQ_READ: begin
          out_value_nxt = smmr_pkg::VAL_W'($signed(rd_val));
          out_arg_nxt   = ent_arg;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_addr_nxt  = pend_addr_r;
    pend_data_nxt  = pend_data_r;
    if (pn_en) begin
      pend_valid_nxt = 1'b1;
      pend_addr_nxt  = new_seg;
      pend_data_nxt  = pn_data;
    end else if (!wa_en) begin
      pend_valid_nxt = 1'b0;
    end else if (wa_addr == pend_addr_r) begin
      pend_valid_nxt = 1'b0;
    end
  end

  assign wr_en   = wa_en || pend_valid_r;
  assign wr_addr = wa_en ? wa_addr : pend_addr_r;
  assign wr_data = wa_en ? wa_data : pend_data_r;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req_r  <= smmr_pkg::req_t'(in_req_type);
      s1_seg_r  <= in_seg;
      s1_val_r  <= DATA_WIDTH'($unsigned(in_value));
      s1_last_r <= in_last_in_row;
    end
    pend_addr_r <= pend_addr_nxt;
    pend_data_r <= pend_data_nxt;
    out_value_r <= out_value_nxt;
    out_arg_r   <= out_arg_nxt;
    out_err_r   <= out_err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      run_val_r    <= '0;
      run_arg_r    <= '0;
      cur_seg_r    <= '0;
      pos_r        <= '0;
      in_row_r     <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      s1_valid_r   <= (in_valid && in_ready) || (s1_valid_r && !s1_fire);
      run_val_r    <= run_val_nxt;
      run_arg_r    <= run_arg_nxt;
      cur_seg_r    <= cur_seg_nxt;
      pos_r        <= pos_nxt;
      in_row_r     <= in_row_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_value_r;
  assign out_read_arg    = out_arg_r;
  assign out_order_error = out_err_r;

endmodule

`default_nettype wire

>>> hdl/segment_min_max_reduce_core.sv
// Segment min/max reducer top level: configuration registers, segment wrap, store and engine.
// Usage:
//   Input channel (in_valid/in_ready): one request per item; req_type selects
//   element, store write or store read. Every item yields exactly one result
//   on the output channel (out_valid/out_ready), in order. The user writes
//   configuration (cfg_we/cfg_index/cfg_data) only while idle; the block does not enforce it.
// Pipeline: an accepted item waits in the engine stage register and moves into the
//   output register when the output is free; out_valid is driven by that register.
// Throughput: one item per cycle sustained while the output is not stalled. The segment
//   store has one read port (issued at acceptance) and one write port; a segment
//   change at the last element of a row needs two write-backs, and the second
//   waits in a one-entry buffer that drains on the next cycle without a store write.
// Reset: rst_n (synchronous, active low) clears the pipeline, the running
//   pair and the row state, and restores register defaults (min mode,
//   row_length 4096, zero_empty 1). Store contents are undefined until written.
// Back-pressure: with out_ready low the output register holds, the engine
//   stage holds its item, and in_ready stays low while that item is held.
`default_nettype none

module segment_min_max_reduce_core #(
  parameter int SEGMENT_COUNT = 1024,
  parameter int ROW_MAX       = 4096,
  parameter int DATA_WIDTH    = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [smmr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [smmr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [smmr_pkg::REQ_W-1:0]           in_req_type,
  input  wire logic [smmr_pkg::SEG_IN_W-1:0]        in_segment,
  input  wire logic signed [smmr_pkg::VAL_W-1:0]    in_value,
  input  wire logic                                 in_last_in_row,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [smmr_pkg::VAL_W-1:0]         out_read_value,
  output logic [smmr_pkg::ARG_W-1:0]                out_read_arg,
  output logic                                      out_order_error
);

  localparam int SEG_W    = $clog2(SEGMENT_COUNT);
  localparam int SEG_IN_W = smmr_pkg::SEG_IN_W;
  localparam int ENT_W    = DATA_WIDTH + smmr_pkg::ARG_W;

  smmr_pkg::cfg_t cfg_r, cfg_nxt;

  logic [SEG_IN_W-1:0] seg_rem;
  logic [SEG_W-1:0]    seg_addr;
  logic                in_acc;
  logic [ENT_W-1:0]    rd_data;
  logic                wr_en;
  logic [SEG_W-1:0]    wr_addr;
  logic [ENT_W-1:0]    wr_data;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (smmr_pkg::cfg_idx_t'(cfg_index))
        smmr_pkg::CFG_REDUCE_MODE: cfg_nxt.reduce_mode = cfg_data[0];
        smmr_pkg::CFG_ROW_LENGTH:  cfg_nxt.row_length  = cfg_data;
        smmr_pkg::CFG_ZERO_EMPTY:  cfg_nxt.zero_empty  = cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reduce_mode <= smmr_pkg::MODE_MIN;
      cfg_r.row_length  <= smmr_pkg::ARG_W'(4096);
      cfg_r.zero_empty  <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // segment modulo SEGMENT_COUNT by restoring compare/subtract
  always_comb begin
    seg_rem = in_segment;
    for (int k = SEG_IN_W - 1; k >= 0; k--) begin
      if ((longint'(SEGMENT_COUNT) << k) < (longint'(1) << SEG_IN_W)) begin
        if (seg_rem >= SEG_IN_W'(SEGMENT_COUNT << k)) begin
          seg_rem = seg_rem - SEG_IN_W'(SEGMENT_COUNT << k);
        end
      end
    end
  end

  assign seg_addr = SEG_W'(seg_rem);
  assign in_acc   = in_valid && in_ready;

  smmr_store #(
    .DEPTH  (SEGMENT_COUNT),
    .ADDR_W (SEG_W),
    .WORD_W (ENT_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (seg_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  smmr_engine #(
    .SEGMENT_COUNT (SEGMENT_COUNT),
    .ROW_MAX       (ROW_MAX),
    .DATA_WIDTH    (DATA_WIDTH)
  ) u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_seg          (seg_addr),
    .in_value        (in_value),
    .in_last_in_row  (in_last_in_row),
    .rd_data         (rd_data),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_value  (out_read_value),
    .out_read_arg    (out_read_arg),
    .out_order_error (out_order_error)
  );

endmodule

`default_nettype wire

>>> hdl/smmr_checker.sv
// Port-level assertion checker for the segment min/max reducer, bound to the top level.
`default_nettype none

`include "segment_min_max_reduce_core_macros.svh"

module smmr_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            cfg_we,
  input wire logic [smmr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input wire logic [smmr_pkg::CFG_DATA_W-1:0] cfg_data,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic [smmr_pkg::REQ_W-1:0]      in_req_type,
  input wire logic [smmr_pkg::SEG_IN_W-1:0]   in_segment,
  input wire logic [smmr_pkg::VAL_W-1:0]      in_value,
  input wire logic                            in_last_in_row,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [smmr_pkg::VAL_W-1:0]      out_read_value,
  input wire logic [smmr_pkg::ARG_W-1:0]      out_read_arg,
  input wire logic                            out_order_error
);

  `SMMR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_read_value) && $stable(out_read_arg) && $stable(out_order_error), "stalled result changed")

  `SMMR_ASSERT_RST(a_rst_clears, !rst_n, !out_valid, "result valid after reset")

  `SMMR_ASSERT_NOW(a_err_payload, out_valid && out_order_error, out_read_value == '0 && out_read_arg == '0, "order error with nonzero read fields")

  `SMMR_ASSERT_NOW(a_ready_only_stall, !in_ready, out_valid && !out_ready, "input blocked without output stall")

endmodule

bind segment_min_max_reduce_core smmr_checker u_smmr_checker (.*);

`default_nettype wire

>>> bench/tb_segment_min_max_reduce_core.sv
// Self-checking testbench for the segment min/max reducer with argument.
`timescale 1ns / 100ps

module tb_segment_min_max_reduce_core;
  import smmr_pkg::*;

  localparam int SEG_MAX = 1023;
  localparam int POS_W = 12;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int LONG_ROW = 4200;
  localparam logic [SEG_IN_W-1:0] LONG_SEG = 10'd700;
  localparam int DRAIN_CYCLES = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_CAP = 40;

  typedef struct packed {
    logic [REQ_W-1:0]    req;
    logic [SEG_IN_W-1:0] seg;
    logic [VAL_W-1:0]    value;
    logic                last;
  } request_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [ARG_W-1:0] arg;
    logic             order_error;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_REDUCE_MODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [REQ_W-1:0] in_req_type = '0;
  logic [SEG_IN_W-1:0] in_segment = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic in_last_in_row = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [VAL_W-1:0] out_read_value;
  logic [ARG_W-1:0] out_read_arg;
  logic out_order_error;

  segment_min_max_reduce_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_segment(in_segment),
    .in_value(in_value), .in_last_in_row(in_last_in_row),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_read_value(out_read_value), .out_read_arg(out_read_arg),
    .out_order_error(out_order_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Reducer state as predicted
  logic [VAL_W-1:0] seg_val [SEG_MAX+1];
  logic [ARG_W-1:0] seg_arg [SEG_MAX+1];
  logic [VAL_W-1:0] run_val = '0;
  logic [ARG_W-1:0] run_arg = '0;
  logic [SEG_IN_W-1:0] run_seg = '0;
  logic [POS_W-1:0] run_pos = '0;
  logic run_active = 1'b0;
  logic mode_now = MODE_MIN;
  logic [ARG_W-1:0] row_len_now = 13'd4096;
  logic zero_empty_now = 1'b1;

  // Stimulus bookkeeping: which entries hold data, and where a row stands
  bit seg_written [SEG_MAX+1];
  logic [SEG_IN_W-1:0] known_segs[$];
  logic [SEG_IN_W-1:0] recent_segs[$];
  logic [SEG_IN_W-1:0] plan_seg = '0;
  logic plan_in_row = 1'b0;

  request_t request_queue[$];
  outcome_t predicted_results[$];
  request_t cur_item = '0;
  outcome_t want;
  logic req_taken = 1'b0;
  logic calm = 1'b0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int issued_count = 0;
  int accepted_count = 0;
  int errors = 0;

  function automatic logic wins(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
    return (mode_now == MODE_MAX) ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
  endfunction

  function automatic outcome_t apply_request(input request_t it);
    outcome_t r;
    logic [VAL_W-1:0] v;
    r = '0;
    case (it.req)
      REQ_ELEM: begin
        if (run_active && it.seg < run_seg) begin
          r.order_error = 1'b1;
        end else begin
          if (!run_active) begin
            run_seg = it.seg;
            run_val = seg_val[it.seg];
            run_arg = seg_arg[it.seg];
            run_pos = '0;
            run_active = 1'b1;
          end else if (it.seg > run_seg) begin
            seg_val[run_seg] = run_val;
            seg_arg[run_seg] = run_arg;
            run_seg = it.seg;
            run_val = seg_val[it.seg];
            run_arg = seg_arg[it.seg];
          end
          if (wins(it.value, run_val)) begin
            run_val = it.value;
            run_arg = {1'b0, run_pos};
          end
          if (it.last) begin
            seg_val[run_seg] = run_val;
            seg_arg[run_seg] = run_arg;
            run_active = 1'b0;
            run_pos = '0;
          end else if (run_pos != POS_MAX) begin
            run_pos = run_pos + 1'b1;
          end
        end
      end
      REQ_WRITE: begin
        seg_val[it.seg] = it.value;
        seg_arg[it.seg] = row_len_now;
      end
      REQ_READ: begin
        v = seg_val[it.seg];
        if (zero_empty_now && v == ((mode_now == MODE_MAX) ? VAL_MIN : VAL_MAX)) v = '0;
        r.value = v;
        r.arg = seg_arg[it.seg];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic coin();
    return $urandom_range(0, 1) == 1;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2, 3: return VAL_W'($urandom_range(0, 8)) - VAL_W'(4);
      default: return $urandom();
    endcase
  endfunction

  function automatic void note_recent(input logic [SEG_IN_W-1:0] seg);
    recent_segs.push_back(seg);
    if (recent_segs.size() > 8) void'(recent_segs.pop_front());
  endfunction

  function automatic logic [SEG_IN_W-1:0] known_seg();
    if (recent_segs.size() != 0 && coin())
      return recent_segs[$urandom_range(0, recent_segs.size() - 1)];
    return known_segs[$urandom_range(0, known_segs.size() - 1)];
  endfunction

  task automatic queue_request(input logic [REQ_W-1:0] req, input logic [SEG_IN_W-1:0] seg,
                               input logic [VAL_W-1:0] value, input logic last);
    request_t it;
    it.req = req;
    it.seg = seg;
    it.value = value;
    it.last = last;
    request_queue.push_back(it);
    issued_count++;
    if (req == REQ_WRITE) begin
      if (!seg_written[seg]) known_segs.push_back(seg);
      seg_written[seg] = 1'b1;
      note_recent(seg);
    end
  endtask

  // Elements that load an entry never written get a write of that entry first.
  task automatic plan_request(input logic [REQ_W-1:0] req, input logic [SEG_IN_W-1:0] seg,
                              input logic [VAL_W-1:0] value, input logic last);
    if (req == REQ_ELEM && (!plan_in_row || seg > plan_seg)) begin
      if (!seg_written[seg]) queue_request(REQ_WRITE, seg, rand_value(), coin());
      plan_seg = seg;
      plan_in_row = 1'b1;
      note_recent(seg);
    end
    if (req == REQ_ELEM && plan_in_row && seg == plan_seg && last) plan_in_row = 1'b0;
    queue_request(req, seg, value, last);
  endtask

  task automatic random_row();
    logic [SEG_IN_W-1:0] seg;
    int unsigned n;
    int unsigned pick;
    int unsigned nxt;
    if (plan_in_row && $urandom_range(0, 9) != 0) seg = plan_seg;
    else if ($urandom_range(0, 9) < 7) seg = SEG_IN_W'($urandom_range(0, 63));
    else seg = SEG_IN_W'($urandom_range(0, SEG_MAX));
    n = $urandom_range(1, 10);
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8)
        plan_request(REQ_READ, known_seg(), rand_value(), coin());
      else if (pick < 12)
        plan_request(REQ_WRITE, coin() ? seg : SEG_IN_W'($urandom_range(0, SEG_MAX)),
                     rand_value(), coin());
      else if (pick < 13)
        plan_request(REQ_UNUSED, SEG_IN_W'($urandom_range(0, SEG_MAX)), $urandom(), coin());
      else if (pick >= 92 && plan_in_row && plan_seg != 0)
        plan_request(REQ_ELEM, SEG_IN_W'($urandom_range(0, plan_seg - 1)), rand_value(), coin());
      if (pick >= 13 && pick < 40) begin
        nxt = seg + $urandom_range(1, 3);
        seg = (nxt > SEG_MAX) ? SEG_IN_W'(SEG_MAX) : SEG_IN_W'(nxt);
      end
      plan_request(REQ_ELEM, seg, rand_value(),
                   (k == n - 1) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0));
    end
    repeat ($urandom_range(0, 3)) plan_request(REQ_READ, known_seg(), rand_value(), coin());
  endtask

  task automatic long_row();
    logic [VAL_W-1:0] v;
    plan_request(REQ_WRITE, LONG_SEG, VAL_MAX, 1'b0);
    for (int p = 0; p < LONG_ROW; p++) begin
      if (p < POS_MAX - 1) v = VAL_W'($urandom_range(0, 1000000));
      else v = VAL_W'(-p);
      plan_request(REQ_ELEM, LONG_SEG, v, p == LONG_ROW - 1);
    end
    plan_request(REQ_READ, LONG_SEG, '0, 1'b0);
  endtask

  task automatic set_config(input logic mode, input logic [ARG_W-1:0] row_len, input logic zero);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_REDUCE_MODE;
    cfg_data <= {{(CFG_DATA_W-1){1'b0}}, mode};
    @(negedge clk);
    cfg_index <= CFG_ROW_LENGTH;
    cfg_data <= row_len;
    @(negedge clk);
    cfg_index <= CFG_ZERO_EMPTY;
    cfg_data <= {{(CFG_DATA_W-1){1'b0}}, zero};
    @(negedge clk);
    cfg_we <= 1'b0;
    mode_now = mode;
    row_len_now = row_len;
    zero_empty_now = zero;
  endtask

  task automatic drain();
    while (accepted_count != issued_count || predicted_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic flag_mismatch(input string field, input logic [VAL_W-1:0] exp_v,
                               input logic [VAL_W-1:0] got_v);
    if (errors < REPORT_CAP)
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field,
               $signed(exp_v), $signed(got_v));
    errors++;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    set_config(MODE_MIN, 13'd4096, 1'b1);
    plan_request(REQ_WRITE, 10'd0, VAL_MAX, 1'b0);
    plan_request(REQ_WRITE, 10'd1023, VAL_MIN, 1'b1);
    plan_request(REQ_READ, 10'd0, '0, 1'b0);
    plan_request(REQ_READ, 10'd1023, '0, 1'b0);
    plan_request(REQ_ELEM, 10'd0, 32'd5, 1'b0);
    plan_request(REQ_ELEM, 10'd0, 32'd5, 1'b0);
    plan_request(REQ_WRITE, 10'd0, -32'sd100, 1'b0);
    plan_request(REQ_READ, 10'd0, '0, 1'b0);
    plan_request(REQ_ELEM, 10'd1023, VAL_MIN, 1'b0);
    plan_request(REQ_ELEM, 10'd0, -32'sd7, 1'b1);
    plan_request(REQ_ELEM, 10'd1023, VAL_MAX, 1'b1);
    plan_request(REQ_READ, 10'd0, '0, 1'b0);
    plan_request(REQ_READ, 10'd1023, '0, 1'b0);
    plan_request(REQ_UNUSED, 10'd1023, '1, 1'b1);
    plan_request(REQ_ELEM, 10'd0, VAL_MIN, 1'b1);
    plan_request(REQ_READ, 10'd0, '0, 1'b0);
    drain();

    calm = 1'b1;
    set_config(MODE_MIN, ARG_W'($urandom_range(1, 4096)), 1'b0);
    long_row();
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_config(MODE_MAX, 13'd1, 1'b0);
        1: set_config(MODE_MIN, 13'd4096, 1'b0);
        2: set_config(MODE_MAX, 13'd4096, 1'b1);
        3: set_config(MODE_MIN, 13'd1, 1'b1);
        default: set_config(coin(), ARG_W'($urandom_range(1, 4096)), coin());
      endcase
      calm = (ph % 3 == 2);
      while (issued_count < LONG_ROW + 60 + (ph + 1) * 130) random_row();
      drain();
    end

    if (errors == 0 && predicted_results.size() == 0)
      $display("** segment_min_max_reduce_core: PASSED **");
    else
      $display("** segment_min_max_reduce_core: FAILED **");
    $finish;
  end

  // Driver: acceptance and prediction at the rising edge, new item at the falling edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      predicted_results.push_back(apply_request(cur_item));
      accepted_count++;
    end
    req_taken <= rst_n && in_valid && in_ready;
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || req_taken)) begin
      if (send_gap != 0 || request_queue.size() == 0) begin
        in_valid <= 1'b0;
        if (send_gap != 0) send_gap--;
      end else begin
        cur_item = request_queue.pop_front();
        in_valid <= 1'b1;
        in_req_type <= cur_item.req;
        in_segment <= cur_item.seg;
        in_value <= cur_item.value;
        in_last_in_row <= cur_item.last;
        send_gap = gap_len();
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 2) == 0) stall_left = gap_len();
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (predicted_results.size() == 0) begin
        if (errors < REPORT_CAP)
          $display("%0t: result with none expected: value %0d arg %0d order_error %0b",
                   $time, out_read_value, out_read_arg, out_order_error);
        errors++;
      end else begin
        want = predicted_results.pop_front();
        if (out_read_value !== want.value)
          flag_mismatch("read_value", want.value, out_read_value);
        if (out_read_arg !== want.arg)
          flag_mismatch("read_arg", VAL_W'(want.arg), VAL_W'(out_read_arg));
        if (out_order_error !== want.order_error)
          flag_mismatch("order_error", VAL_W'(want.order_error), VAL_W'(out_order_error));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles = 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("** segment_min_max_reduce_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

endmodule
